// File: rtl/core/bounded_positional_list_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded positional list
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_POSITIONAL_LIST_TOP_DEFINES_SVH
`define BOUNDED_POSITIONAL_LIST_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BLP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: blp same-cycle check");

// Next-cycle implication.
`define BLP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: blp next-cycle check");

`else

`define BLP_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BLP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/blp_pkg.sv
// ----------------------------------------------------------------------------
// blp_pkg
// Sizes, codes and the cell control type of the bounded positional list.
// ----------------------------------------------------------------------------
`default_nettype none

package blp_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W   = 4;
    localparam int CMP_W   = (COUNT_W > POS_W + 1) ? COUNT_W : POS_W + 1;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK    = 3'd0,
        CMD_PUSH_FRONT   = 3'd1,
        CMD_POP_FRONT    = 3'd2,
        CMD_POP_BACK     = 3'd3,
        CMD_READ         = 3'd4,
        CMD_INSERT_AFTER = 3'd5,
        CMD_ERASE        = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // Action that every cell takes for the current command
    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_WRITE  = 2'd1,  // load data at idx only
        ACT_INSERT = 2'd2,  // load data at idx, cells above take lower neighbor
        ACT_REMOVE = 2'd3   // cells at and above idx take upper neighbor
    } cell_act_t;

    typedef struct packed {
        cell_act_t               act;
        logic [IDX_W-1:0]        idx;
        logic [DATA_WIDTH-1:0]   data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/bounded_positional_list_top.sv
// ----------------------------------------------------------------------------
// bounded_positional_list_top
// Ordered list of up to CAPACITY words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one command per clock while the result is not stalled, and answers each
// with one result item in the cycle after acceptance, from an output register; a
// new command is taken while the previous result waits, as long as that result
// is taken in the same cycle. Elements live in a row of cells, one word each;
// inserts and erases move every cell above the index by one place in the same
// cycle, so none of the seven commands stalls the input. A failed command leaves
// the list unchanged. Element storage holds no defined value until written; only
// elements below the count are ever read.
`default_nettype none
`include "bounded_positional_list_top_defines.svh"

module bounded_positional_list_top
    import blp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cmd[2:0], position[6:3], entry_data[38:7], pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata    // read_data[31:0], status[33:32],
                                        // entry_count[38:34], pad
);

    logic                  s_accept;
    cmd_t                  cmd;
    logic [POS_W-1:0]      position;
    logic [31:0]           entry_data;

    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [31:0]           m_read_data_reg;
    status_t               m_status_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic [31:0]           read_data;
    status_t               status;
    cell_ctrl_t            cell_ctrl;
    logic                  is_full;
    logic                  is_empty;
    logic                  pos_bad;
    logic [CMP_W-1:0]      pos_plus_one;

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign cmd        = cmd_t'(s_tdata[2:0]);
    assign position   = s_tdata[6:3];
    assign entry_data = s_tdata[38:7];

    assign is_full      = (count_reg == COUNT_W'(CAPACITY));
    assign is_empty     = (count_reg == '0);
    assign pos_bad      = (CMP_W'(position) >= CMP_W'(count_reg));
    assign pos_plus_one = CMP_W'(position) + CMP_W'(1);

    // Command decode: status, count update and the broadcast to the cells
    always_comb begin
        read_data      = '0;
        status         = ST_OK;
        count_next     = count_reg;
        cell_ctrl.act  = ACT_HOLD;
        cell_ctrl.idx  = '0;
        cell_ctrl.data = DATA_WIDTH'(entry_data);
        case (cmd)
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    cell_ctrl.act = ACT_WRITE;
                    cell_ctrl.idx = IDX_W'(count_reg);
                    count_next    = count_reg + COUNT_W'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    cell_ctrl.act = ACT_INSERT;
                    count_next    = count_reg + COUNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    cell_ctrl.act = ACT_REMOVE;
                    count_next    = count_reg - COUNT_W'(1);
                end
            end
            CMD_POP_BACK: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            CMD_READ: begin
                if (pos_bad) begin
                    status = ST_BADIDX;
                end else begin
                    read_data = 32'(cell_q[IDX_W'(position)]);
                end
            end
            CMD_INSERT_AFTER: begin
                if (is_full) begin
                    status = ST_FULL;
                end else if (pos_bad) begin
                    status = ST_BADIDX;
                end else begin
                    cell_ctrl.act = ACT_INSERT;
                    cell_ctrl.idx = IDX_W'(pos_plus_one);
                    count_next    = count_reg + COUNT_W'(1);
                end
            end
            CMD_ERASE: begin
                if (pos_bad) begin
                    status = ST_BADIDX;
                end else begin
                    cell_ctrl.act = ACT_REMOVE;
                    cell_ctrl.idx = IDX_W'(position);
                    count_next    = count_reg - COUNT_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        // hold everything unless an item is taken this cycle
        if (!s_accept) begin
            cell_ctrl.act = ACT_HOLD;
            count_next    = count_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] lower_data;
            logic [DATA_WIDTH-1:0] upper_data;
            if (gi == 0) begin : g_first
                assign lower_data = cell_q[gi];
            end else begin : g_lower
                assign lower_data = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign upper_data = cell_q[gi];
            end else begin : g_upper
                assign upper_data = cell_q[gi+1];
            end
            blp_cell u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .cell_index (IDX_W'(gi)),
                .lower_data (lower_data),
                .upper_data (upper_data),
                .cell_data  (cell_q[gi])
            );
        end
    endgenerate

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_read_data_reg <= read_data;
            m_status_reg    <= status;
            m_count_reg     <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, 5'(m_count_reg), m_status_reg, m_read_data_reg};

    `BLP_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= COUNT_W'(CAPACITY))
    `BLP_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_accept, m_tvalid_reg)
    `BLP_ASSERT_NEXT(a_full_push, aclk, aresetn, s_accept && is_full && (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT), m_status_reg == ST_FULL && count_reg == $past(count_reg))
    `BLP_ASSERT_NEXT(a_empty_pop, aclk, aresetn, s_accept && is_empty && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK), m_status_reg == ST_EMPTY && count_reg == '0)
    `BLP_ASSERT_NEXT(a_count_report, aclk, aresetn, s_accept, m_count_reg == count_reg)

endmodule

`default_nettype wire

// File: rtl/core/blp_cell.sv
// ----------------------------------------------------------------------------
// blp_cell
// One list slot: holds a data word, loads, or takes a neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_cell
    import blp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [IDX_W-1:0]      cell_index,
    input  wire logic [DATA_WIDTH-1:0] lower_data,
    input  wire logic [DATA_WIDTH-1:0] upper_data,
    output logic      [DATA_WIDTH-1:0] cell_data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.act)
            ACT_WRITE: begin
                if (cell_index == ctrl.idx) begin
                    data_next = ctrl.data;
                end
            end
            ACT_INSERT: begin
                if (cell_index == ctrl.idx) begin
                    data_next = ctrl.data;
                end else if (cell_index > ctrl.idx) begin
                    data_next = lower_data;
                end
            end
            ACT_REMOVE: begin
                if (cell_index >= ctrl.idx) begin
                    data_next = upper_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_data = data_reg;

endmodule

`default_nettype wire
